@@ hdl/i2cra_pkg.sv @@
// Package for the I2C register access master: shared types, codes and constants.
// Holds the bus phase and step enums, the item and result structs and the step tables.
// Depends on nothing.
`default_nettype none

package i2cra_pkg;

    localparam int FRONT_DEPTH_DEF = 2;
    localparam int RSLT_DEPTH_DEF  = 2;

    localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'd104;
    localparam logic [15:0] PHASE_TICKS_RST    = 16'd5;

    localparam logic [3:0] WRITE_STEP_COUNT = 4'd5;
    localparam logic [3:0] READ_STEP_COUNT  = 4'd8;
    localparam logic [3:0] BITS_PER_BYTE    = 4'd8;

    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_PHASE_TICKS    = 1'b1;

    typedef enum logic [1:0] {
        REQ_NONE      = 2'd0,
        REQ_WRITE     = 2'd1,
        REQ_READ_BYTE = 2'd2,
        REQ_READ_WORD = 2'd3
    } t_req;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_START_A  = 5'd1,
        PH_START_B  = 5'd2,
        PH_TX_SETUP = 5'd3,
        PH_TX_HIGH  = 5'd4,
        PH_TX_LOW   = 5'd5,
        PH_ACK_A    = 5'd6,
        PH_ACK_B    = 5'd7,
        PH_RX_A     = 5'd8,
        PH_RX_B     = 5'd9,
        PH_RX_C     = 5'd10,
        PH_RX_D     = 5'd11,
        PH_MACK_A   = 5'd12,
        PH_MACK_B   = 5'd13,
        PH_MACK_C   = 5'd14,
        PH_STOP_A   = 5'd15,
        PH_STOP_B   = 5'd16
    } t_phase;

    typedef enum logic [2:0] {
        K_START     = 3'd0,
        K_TX_ADDR_W = 3'd1,
        K_TX_REG    = 3'd2,
        K_TX_DATA   = 3'd3,
        K_TX_ADDR_R = 3'd4,
        K_RX        = 3'd5,
        K_MACK      = 3'd6,
        K_STOP      = 3'd7
    } t_kind;

    typedef struct packed {
        logic       start_req;
        t_req       req;
        logic [7:0] target_reg;
        logic [7:0] write_data;
        logic       sda;
    } t_cmd;

    typedef struct packed {
        logic        scl;
        logic        sda_pull_low;
        logic        busy;
        logic        done;
        logic [15:0] read_data;
        logic        nack;
    } t_result;

    typedef struct packed {
        t_phase     phase;
        logic       load;
        logic [7:0] tx_byte;
    } t_begin;

    function automatic t_kind f_step_kind(t_req req, logic [2:0] step);
        t_kind k;
        k = K_STOP;
        if (req == REQ_WRITE) begin
            case (step)
                3'd0: k = K_START;
                3'd1: k = K_TX_ADDR_W;
                3'd2: k = K_TX_REG;
                3'd3: k = K_TX_DATA;
                default: k = K_STOP;
            endcase
        end else begin
            case (step)
                3'd0: k = K_START;
                3'd1: k = K_TX_ADDR_W;
                3'd2: k = K_TX_REG;
                3'd3: k = K_START;
                3'd4: k = K_TX_ADDR_R;
                3'd5: k = K_RX;
                3'd6: k = K_MACK;
                default: k = K_STOP;
            endcase
        end
        return k;
    endfunction

    function automatic t_begin f_begin(t_kind k, logic [6:0] dev, logic [7:0] reg_addr,
                                       logic [7:0] wdata, logic second);
        t_begin b;
        b.phase   = PH_STOP_A;
        b.load    = 1'b0;
        b.tx_byte = 8'h00;
        case (k)
            K_START: begin
                b.phase = PH_START_A;
            end
            K_TX_ADDR_W: begin
                b.phase   = PH_TX_SETUP;
                b.load    = 1'b1;
                b.tx_byte = {dev, 1'b0};
            end
            K_TX_ADDR_R: begin
                b.phase   = PH_TX_SETUP;
                b.load    = 1'b1;
                b.tx_byte = {dev, 1'b1};
            end
            K_TX_REG: begin
                b.phase   = PH_TX_SETUP;
                b.load    = 1'b1;
                b.tx_byte = reg_addr + {7'd0, second};
            end
            K_TX_DATA: begin
                b.phase   = PH_TX_SETUP;
                b.load    = 1'b1;
                b.tx_byte = wdata;
            end
            K_RX: begin
                b.phase   = PH_RX_A;
                b.load    = 1'b1;
                b.tx_byte = 8'h00;
            end
            K_MACK: begin
                b.phase = PH_MACK_A;
            end
            default: begin
                b.phase = PH_STOP_A;
            end
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ hdl/i2cra_fifo.sv @@
// Small first-in first-out queue of register entries, used on both sides of the sequencer.
// Generic width and depth; no package dependency.
`default_nettype none

module i2cra_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/i2cra_front.sv @@
// Front end of the I2C register access master: takes tick items and classifies the request.
// Uses i2cra_pkg and queues classified items in an i2cra_fifo.
`default_nettype none

module i2cra_front
    import i2cra_pkg::*;
#(
    parameter int DEPTH = FRONT_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [1:0] i_req_type,
    input  wire logic [7:0] i_target_reg,
    input  wire logic [7:0] i_write_data,
    input  wire logic       i_sda_in,
    input  wire logic       i_cmd_pop,
    output t_cmd            o_cmd,
    output logic            o_cmd_empty
);

    t_cmd                   w_cmd;
    logic [$bits(t_cmd)-1:0] w_q_out;

    always_comb begin
        w_cmd.req         = t_req'(i_req_type);
        w_cmd.start_req   = (w_cmd.req != REQ_NONE);
        w_cmd.target_reg  = i_target_reg;
        w_cmd.write_data  = i_write_data;
        w_cmd.sda         = i_sda_in;
    end

    i2cra_fifo #(
        .WIDTH($bits(t_cmd)),
        .DEPTH(DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_push),
        .i_data (w_cmd),
        .o_full (o_full),
        .i_pop  (i_cmd_pop),
        .o_data (w_q_out),
        .o_empty(o_cmd_empty)
    );

    assign o_cmd = t_cmd'(w_q_out);

endmodule

`default_nettype wire

@@ hdl/i2cra_seq.sv @@
// Bus sequencer of the I2C register access master: advances the bus by one tick per item.
// Uses i2cra_pkg for phases, step tables and the result struct.
`default_nettype none

module i2cra_seq
    import i2cra_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire t_cmd        i_cmd,
    input  wire logic [6:0]  i_device_address,
    input  wire logic [15:0] i_phase_ticks,
    output t_result          o_result
);

    t_phase      r_phase, n_phase, a_phase;
    logic [15:0] r_tick, n_tick, a_tick;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_word, n_word;
    logic        r_nack, n_nack, a_nack;
    t_req        r_req, n_req, a_req;
    logic [7:0]  r_reg, n_reg, a_reg;
    logic [7:0]  r_data, n_data, a_data;
    logic        r_second, n_second, a_second;
    logic [2:0]  r_step, n_step, a_step;
    logic        n_done;

    // A request is taken only while the bus is idle; it starts with the start condition.
    always_comb begin : accept_logic
        a_phase  = r_phase;
        a_tick   = r_tick;
        a_nack   = r_nack;
        a_req    = r_req;
        a_reg    = r_reg;
        a_data   = r_data;
        a_second = r_second;
        a_step   = r_step;
        if (r_phase == PH_IDLE && i_cmd.start_req) begin
            a_req    = i_cmd.req;
            a_reg    = i_cmd.target_reg;
            a_data   = i_cmd.write_data;
            a_nack   = 1'b0;
            a_second = 1'b0;
            a_step   = '0;
            a_tick   = '0;
            a_phase  = PH_START_A;
        end
    end

    always_comb begin : next_state
        logic [15:0] v_tick;
        logic [15:0] v_limit;
        logic        v_end;
        logic        v_begin;
        logic [3:0]  v_step_inc;
        logic [3:0]  v_count;
        logic [3:0]  v_bit;
        t_begin      v_b;
        n_phase  = a_phase;
        n_tick   = a_tick;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_word   = r_word;
        n_nack   = a_nack;
        n_req    = a_req;
        n_reg    = a_reg;
        n_data   = a_data;
        n_second = a_second;
        n_step   = a_step;
        n_done   = 1'b0;
        v_end    = 1'b0;
        v_begin  = 1'b0;
        v_tick   = a_tick + 16'd1;
        v_limit  = (i_phase_ticks == '0) ? 16'd1 : i_phase_ticks;
        v_bit    = r_bit + 4'd1;
        v_count  = (a_req == REQ_WRITE) ? WRITE_STEP_COUNT : READ_STEP_COUNT;
        v_step_inc = {1'b0, a_step} + 4'd1;
        if (a_phase != PH_IDLE) begin
            if (v_tick >= v_limit) begin
                n_tick = '0;
                case (a_phase)
                    PH_START_A:  n_phase = PH_START_B;
                    PH_TX_SETUP: n_phase = PH_TX_HIGH;
                    PH_TX_HIGH:  n_phase = PH_TX_LOW;
                    PH_TX_LOW: begin
                        n_shift = {r_shift[6:0], 1'b0};
                        n_bit   = v_bit;
                        n_phase = (v_bit >= BITS_PER_BYTE) ? PH_ACK_A : PH_TX_SETUP;
                    end
                    PH_ACK_A: begin
                        if (i_cmd.sda) begin
                            n_nack = 1'b1;
                        end
                        n_phase = PH_ACK_B;
                    end
                    PH_RX_A: n_phase = PH_RX_B;
                    PH_RX_B: begin
                        n_shift = {r_shift[6:0], i_cmd.sda};
                        n_phase = PH_RX_C;
                    end
                    PH_RX_C: n_phase = PH_RX_D;
                    PH_RX_D: begin
                        n_bit = v_bit;
                        if (v_bit >= BITS_PER_BYTE) begin
                            if (a_req == REQ_READ_WORD && !a_second) begin
                                n_word = {r_shift, 8'h00};
                            end else if (a_req == REQ_READ_WORD) begin
                                n_word = {r_word[15:8], r_shift};
                            end else begin
                                n_word = {8'h00, r_shift};
                            end
                            v_end = 1'b1;
                        end else begin
                            n_phase = PH_RX_A;
                        end
                    end
                    PH_MACK_A: n_phase = PH_MACK_B;
                    PH_MACK_B: n_phase = PH_MACK_C;
                    PH_STOP_A: n_phase = PH_STOP_B;
                    default:   v_end = 1'b1;
                endcase
            end else begin
                n_tick = v_tick;
            end
        end
        if (v_end) begin
            if (v_step_inc < v_count) begin
                n_step  = v_step_inc[2:0];
                v_begin = 1'b1;
            end else if (a_req == REQ_READ_WORD && !a_second) begin
                n_second = 1'b1;
                n_step   = '0;
                v_begin  = 1'b1;
            end else begin
                n_phase  = PH_IDLE;
                n_req    = REQ_NONE;
                n_second = 1'b0;
                n_step   = '0;
                n_done   = 1'b1;
            end
        end
        v_b = f_begin(f_step_kind(n_req, n_step), i_device_address, n_reg, n_data, n_second);
        if (v_begin) begin
            n_phase = v_b.phase;
            if (v_b.load) begin
                n_shift = v_b.tx_byte;
                n_bit   = '0;
            end
        end
    end

    always_comb begin : output_logic
        logic v_bitlow;
        v_bitlow = !r_shift[7];
        o_result.scl          = 1'b0;
        o_result.sda_pull_low = 1'b0;
        case (a_phase)
            PH_IDLE: begin
                o_result.scl          = 1'b1;
                o_result.sda_pull_low = 1'b0;
            end
            PH_START_A: begin
                o_result.scl          = 1'b1;
                o_result.sda_pull_low = 1'b0;
            end
            PH_START_B: begin
                o_result.scl          = 1'b1;
                o_result.sda_pull_low = 1'b1;
            end
            PH_TX_SETUP, PH_TX_LOW: begin
                o_result.scl          = 1'b0;
                o_result.sda_pull_low = v_bitlow;
            end
            PH_TX_HIGH: begin
                o_result.scl          = 1'b1;
                o_result.sda_pull_low = v_bitlow;
            end
            PH_ACK_A, PH_ACK_B, PH_RX_B, PH_RX_C, PH_MACK_B: begin
                o_result.scl          = 1'b1;
                o_result.sda_pull_low = 1'b0;
            end
            PH_STOP_A: begin
                o_result.scl          = 1'b0;
                o_result.sda_pull_low = 1'b1;
            end
            PH_STOP_B: begin
                o_result.scl          = 1'b1;
                o_result.sda_pull_low = 1'b1;
            end
            default: begin
                o_result.scl          = 1'b0;
                o_result.sda_pull_low = 1'b0;
            end
        endcase
        o_result.busy      = (a_phase != PH_IDLE);
        o_result.done      = n_done;
        o_result.read_data = n_word;
        o_result.nack      = n_nack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_tick   <= '0;
            r_bit    <= '0;
            r_shift  <= '0;
            r_word   <= '0;
            r_nack   <= 1'b0;
            r_req    <= REQ_NONE;
            r_reg    <= '0;
            r_data   <= '0;
            r_second <= 1'b0;
            r_step   <= '0;
        end else if (i_go) begin
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_bit    <= n_bit;
            r_shift  <= n_shift;
            r_word   <= n_word;
            r_nack   <= n_nack;
            r_req    <= n_req;
            r_reg    <= n_reg;
            r_data   <= n_data;
            r_second <= n_second;
            r_step   <= n_step;
        end
    end

endmodule

`default_nettype wire

@@ hdl/i2c_register_access_master.sv @@
// I2C register access master: one tick item in, one result item out, one item per cycle
// while the tick queue holds one and the result queue has room. A result passes
// the tick queue and then the result queue before it is visible on the result ports.
// The sequencer takes one item each cycle while both conditions hold.
// Synchronous active-low reset empties both queues, idles the bus and restores
// the device address to 104 and the phase length to 5 ticks.
`default_nettype none

module i2c_register_access_master
    import i2cra_pkg::*;
#(
    parameter int FRONT_DEPTH = FRONT_DEPTH_DEF,
    parameter int RSLT_DEPTH  = RSLT_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_target_reg,
    input  wire logic [7:0]  i_write_data,
    input  wire logic        i_sda_in,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_scl,
    output logic             o_sda_pull_low,
    output logic             o_busy_res,
    output logic             o_done_res,
    output logic [15:0]      o_read_data,
    output logic             o_nack_seen,
    input  wire logic        valid,
    output logic             ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic [6:0]  r_device_address;
    logic [15:0] r_phase_ticks;
    t_cmd        w_cmd;
    logic        w_cmd_empty;
    logic        w_rslt_full;
    logic        w_go;
    t_result     w_rslt_in;
    logic [$bits(t_result)-1:0] w_rslt_raw;
    t_result     w_rslt_out;

    assign ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= DEVICE_ADDRESS_RST;
            r_phase_ticks    <= PHASE_TICKS_RST;
        end else if (valid && ready) begin
            case (i_cfg_index)
                CFG_DEVICE_ADDRESS: r_device_address <= i_cfg_data[6:0];
                CFG_PHASE_TICKS:    r_phase_ticks    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_go = !w_cmd_empty && !w_rslt_full;

    i2cra_front #(
        .DEPTH(FRONT_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_req_type   (i_req_type),
        .i_target_reg (i_target_reg),
        .i_write_data (i_write_data),
        .i_sda_in     (i_sda_in),
        .i_cmd_pop    (w_go),
        .o_cmd        (w_cmd),
        .o_cmd_empty  (w_cmd_empty)
    );

    i2cra_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_go            (w_go),
        .i_cmd           (w_cmd),
        .i_device_address(r_device_address),
        .i_phase_ticks   (r_phase_ticks),
        .o_result        (w_rslt_in)
    );

    i2cra_fifo #(
        .WIDTH($bits(t_result)),
        .DEPTH(RSLT_DEPTH)
    ) u_rslt_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_go),
        .i_data (w_rslt_in),
        .o_full (w_rslt_full),
        .i_pop  (pop),
        .o_data (w_rslt_raw),
        .o_empty(empty)
    );

    assign w_rslt_out     = t_result'(w_rslt_raw);
    assign o_scl          = w_rslt_out.scl;
    assign o_sda_pull_low = w_rslt_out.sda_pull_low;
    assign o_busy_res     = w_rslt_out.busy;
    assign o_done_res     = w_rslt_out.done;
    assign o_read_data    = w_rslt_out.read_data;
    assign o_nack_seen    = w_rslt_out.nack;

    // A finished transaction ends in the second stop segment: clock high, data held low.
    a_done_in_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_rslt_in.done) |-> (w_rslt_in.busy && w_rslt_in.scl &&
                                      w_rslt_in.sda_pull_low))
        else $error("done reported outside the stop segment");

    // An idle bus leaves the clock high and the data line released.
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_busy_res) |-> (o_scl && !o_sda_pull_low))
        else $error("bus driven while idle");

    // An item accepted into an empty front queue is held there for the sequencer.
    a_go_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && w_cmd_empty) |=> !w_cmd_empty)
        else $error("accepted item lost before the sequencer");

endmodule

`default_nettype wire
